### rtl/cir_pkg.sv
// Package with shared constants, codes and the divider payload type.
`default_nettype none
package cir_pkg;

    // Configuration register indexes.
    localparam logic [3:0] REG_RESTITUTION = 4'd0;
    localparam logic [3:0] REG_SLOP        = 4'd1;
    localparam logic [3:0] REG_FRACTION    = 4'd2;
    localparam logic [3:0] REG_RESTING     = 4'd3;

    // Register reset values.
    localparam logic [16:0] RST_RESTITUTION = 17'd58982;
    localparam logic [20:0] RST_SLOP        = 21'd655;
    localparam logic [16:0] RST_FRACTION    = 17'd52429;
    localparam logic [30:0] RST_RESTING     = 31'd25717;

    // Body case codes.
    localparam logic [1:0] CASE_BOTH = 2'd0;
    localparam logic [1:0] CASE_A    = 2'd1;
    localparam logic [1:0] CASE_B    = 2'd2;
    localparam logic [1:0] CASE_NONE = 2'd3;

    // Outcome codes.
    localparam logic [1:0] OUTC_IMPULSE   = 2'd0;
    localparam logic [1:0] OUTC_NO_CHANGE = 2'd1;
    localparam logic [1:0] OUTC_SKIPPED   = 2'd2;

    // Intermediate values are clamped to plus or minus 2^37.
    localparam int MID_W = 39;
    localparam logic signed [63:0] MID_LIMIT = 64'sd1 <<< 37;

    // Contact data that travels alongside the weight divider.
    typedef struct packed {
        logic [1:0]         body_case;
        logic               skip;
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic [30:0]        excess;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } cir_item_t;

endpackage
`default_nettype wire

### rtl/cir_if.sv
// Channel interfaces for contacts, results and configuration writes.
`default_nettype none
interface cir_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         body_case;
    logic [30:0]        inv_mass_a;
    logic [30:0]        inv_mass_b;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic [30:0]        depth;

    modport source (output valid, body_case, inv_mass_a, inv_mass_b, vel_a_x, vel_a_y,
                    vel_b_x, vel_b_y, normal_x, normal_y, depth, input ready);
    modport sink (input valid, body_case, inv_mass_a, inv_mass_b, vel_a_x, vel_a_y,
                  vel_b_x, vel_b_y, normal_x, normal_y, depth, output ready);
endinterface

interface cir_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] shift_a_x;
    logic signed [31:0] shift_a_y;
    logic signed [31:0] shift_b_x;
    logic signed [31:0] shift_b_y;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic [1:0]         outcome;

    modport source (output valid, shift_a_x, shift_a_y, shift_b_x, shift_b_y, new_vel_a_x,
                    new_vel_a_y, new_vel_b_x, new_vel_b_y, outcome, input ready);
    modport sink (input valid, shift_a_x, shift_a_y, shift_b_x, shift_b_y, new_vel_a_x,
                  new_vel_a_y, new_vel_b_x, new_vel_b_y, outcome, output ready);
endinterface

interface cir_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/cir_wdiv.sv
// Pipelined restoring divider producing both body weights, one quotient bit per stage.
`default_nettype none
module cir_wdiv
    import cir_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [30:0]          ima,
    input  wire logic [30:0]          imb,
    input  wire logic [31:0]          tot,
    input  wire cir_item_t            in_item,
    output logic                      out_valid,
    output logic [FRAC_BITS:0]        wa,
    output logic [FRAC_BITS:0]        wb,
    output cir_item_t                 out_item
);

    localparam int STAGES = FRAC_BITS + 1;

    logic [STAGES-1:0]  vld_reg;
    logic [31:0]        ra_reg  [STAGES];
    logic [31:0]        rb_reg  [STAGES];
    logic [31:0]        tot_reg [STAGES];
    logic [FRAC_BITS:0] qa_reg  [STAGES];
    logic [FRAC_BITS:0] qb_reg  [STAGES];
    cir_item_t          item_reg[STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic [32:0]        sa;
        logic [32:0]        sb;
        logic [31:0]        tp;
        logic [FRAC_BITS:0] qap;
        logic [FRAC_BITS:0] qbp;
        logic               vp;
        cir_item_t          ip;
        logic               ga;
        logic               gb;

        if (i == 0) begin : g_first
            // The leading quotient bit needs no shift since each mass is at most the total.
            assign sa  = {2'b00, ima};
            assign sb  = {2'b00, imb};
            assign tp  = tot;
            assign qap = '0;
            assign qbp = '0;
            assign vp  = in_valid;
            assign ip  = in_item;
        end
        else begin : g_next
            assign sa  = {ra_reg[i-1], 1'b0};
            assign sb  = {rb_reg[i-1], 1'b0};
            assign tp  = tot_reg[i-1];
            assign qap = qa_reg[i-1];
            assign qbp = qb_reg[i-1];
            assign vp  = vld_reg[i-1];
            assign ip  = item_reg[i-1];
        end

        assign ga = sa >= {1'b0, tp};
        assign gb = sb >= {1'b0, tp};

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[i] <= 1'b0;
            end
            else if (en) begin
                vld_reg[i] <= vp;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                ra_reg[i]   <= ga ? 32'(sa - {1'b0, tp}) : sa[31:0];
                rb_reg[i]   <= gb ? 32'(sb - {1'b0, tp}) : sb[31:0];
                qa_reg[i]   <= {qap[FRAC_BITS-1:0], ga};
                qb_reg[i]   <= {qbp[FRAC_BITS-1:0], gb};
                tot_reg[i]  <= tp;
                item_reg[i] <= ip;
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign wa        = qa_reg[STAGES-1];
    assign wb        = qb_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];

endmodule
`default_nettype wire

### rtl/contact_impulse_resolver.sv
// Top level of the 2D contact impulse resolver pipeline.
//
// The resolver takes one contact per cycle and returns one result per contact, in order;
// the default data format is Q16.16. Two input stages form the total inverse mass, the
// excess depth and the relative velocity; a restoring divider then spends FRAC_BITS + 1
// stages, one quotient bit each, forming both body weights; seven stages of multiply and
// rescale follow, with at most one multiplication between registers, and an output
// register holds the result. All stages advance together; the pipeline stops only when
// the output register holds a result that is not taken and the last stage carries a
// contact, so a waiting result does not block input while the last stage holds a bubble.
// Configuration writes are taken at any time but must only be issued while the pipeline
// is empty.
`default_nettype none
module contact_impulse_resolver
    import cir_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cir_in_if.sink      in_ch,
    cir_out_if.source   out_ch,
    cir_cfg_if.sink     cfg
);

    localparam int FAC_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [FAC_W-1:0] ONE_Q = FAC_W'(64'sd1 <<< FRAC_BITS);
    localparam int NPOST = 7;

    // Work record carried through the stages after the divider.
    typedef struct packed {
        logic [1:0]                body_case;
        logic                      skip;
        logic signed [31:0]        vax;
        logic signed [31:0]        vay;
        logic signed [31:0]        vbx;
        logic signed [31:0]        vby;
        logic signed [17:0]        nx;
        logic signed [17:0]        ny;
        logic [30:0]               excess;
        logic signed [32:0]        dx;
        logic signed [32:0]        dy;
        logic [FRAC_BITS:0]        wa;
        logic [FRAC_BITS:0]        wb;
        logic [47:0]               corr_raw;
        logic signed [50:0]        pdx;
        logic signed [50:0]        pdy;
        logic signed [MID_W-1:0]   corr;
        logic signed [MID_W-1:0]   vn;
        logic                      approach;
        logic signed [63:0]        imp_raw;
        logic signed [63:0]        ca_raw;
        logic signed [63:0]        cb_raw;
        logic signed [63:0]        shx_raw;
        logic signed [63:0]        shy_raw;
        logic signed [MID_W-1:0]   imp;
        logic signed [MID_W-1:0]   ca;
        logic signed [MID_W-1:0]   cb;
        logic signed [MID_W-1:0]   sh1x;
        logic signed [MID_W-1:0]   sh1y;
        logic signed [63:0]        ia_raw;
        logic signed [63:0]        ib_raw;
        logic signed [63:0]        tax_raw;
        logic signed [63:0]        tay_raw;
        logic signed [63:0]        tbx_raw;
        logic signed [63:0]        tby_raw;
        logic signed [63:0]        d1x_raw;
        logic signed [63:0]        d1y_raw;
        logic signed [MID_W-1:0]   ia;
        logic signed [MID_W-1:0]   ib;
        logic signed [MID_W-1:0]   sax;
        logic signed [MID_W-1:0]   say;
        logic signed [MID_W-1:0]   sbx;
        logic signed [MID_W-1:0]   sby;
        logic signed [MID_W-1:0]   d1x;
        logic signed [MID_W-1:0]   d1y;
        logic signed [63:0]        uax_raw;
        logic signed [63:0]        uay_raw;
        logic signed [63:0]        ubx_raw;
        logic signed [63:0]        uby_raw;
    } work_t;

    // Product rescale: round to nearest with ties upward, then clamp to the mid range.
    function automatic logic signed [MID_W-1:0] rescale(input logic signed [63:0] raw);
        logic signed [63:0] r;
        r = (raw + HALF) >>> FRAC_BITS;
        if (r > MID_LIMIT) begin
            r = MID_LIMIT;
        end
        else if (r < -MID_LIMIT) begin
            r = -MID_LIMIT;
        end
        return MID_W'(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
        logic signed [31:0] r;
        if (x > 41'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -41'sd2147483648) begin
            r = 32'sh80000000;
        end
        else begin
            r = 32'(x);
        end
        return r;
    endfunction

    // Configuration registers.
    logic [16:0] restitution_reg;
    logic [20:0] slop_reg;
    logic [16:0] fraction_reg;
    logic [30:0] resting_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            restitution_reg <= RST_RESTITUTION;
            slop_reg        <= RST_SLOP;
            fraction_reg    <= RST_FRACTION;
            resting_reg     <= RST_RESTING;
        end
        else if (cfg.valid) begin
            case (cfg.index)
                REG_RESTITUTION: restitution_reg <= cfg.data[16:0];
                REG_SLOP:        slop_reg        <= cfg.data[20:0];
                REG_FRACTION:    fraction_reg    <= cfg.data[16:0];
                REG_RESTING:     resting_reg     <= cfg.data[30:0];
                default:         ;
            endcase
        end
    end

    // Global stage enable. A result that waits only stalls the pipeline when the last
    // stage has a contact ready to move into the output register.
    logic en;
    logic last_vld;
    logic out_valid_reg;

    assign en          = !out_valid_reg || out_ch.ready || !last_vld;
    assign in_ch.ready = en;

    // Stage A: input capture.
    logic               a_vld_reg;
    logic [1:0]         a_case_reg;
    logic [30:0]        a_ima_reg;
    logic [30:0]        a_imb_reg;
    logic signed [31:0] a_vax_reg;
    logic signed [31:0] a_vay_reg;
    logic signed [31:0] a_vbx_reg;
    logic signed [31:0] a_vby_reg;
    logic signed [17:0] a_nx_reg;
    logic signed [17:0] a_ny_reg;
    logic [30:0]        a_dep_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
        end
        else if (en) begin
            a_vld_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a_case_reg <= in_ch.body_case;
            a_ima_reg  <= in_ch.inv_mass_a;
            a_imb_reg  <= in_ch.inv_mass_b;
            a_vax_reg  <= in_ch.vel_a_x;
            a_vay_reg  <= in_ch.vel_a_y;
            a_vbx_reg  <= in_ch.vel_b_x;
            a_vby_reg  <= in_ch.vel_b_y;
            a_nx_reg   <= in_ch.normal_x;
            a_ny_reg   <= in_ch.normal_y;
            a_dep_reg  <= in_ch.depth;
        end
    end

    // Stage B: total inverse mass, excess depth and the relative velocity.
    logic        b_vld_reg;
    logic [30:0] b_ima_reg;
    logic [30:0] b_imb_reg;
    logic [31:0] b_tot_reg;
    cir_item_t   b_item_reg;
    logic [31:0] b_tot_next;
    cir_item_t   b_item_next;

    always_comb begin
        b_tot_next            = {1'b0, a_ima_reg} + {1'b0, a_imb_reg};
        b_item_next.body_case = a_case_reg;
        b_item_next.skip      = (a_case_reg == CASE_NONE) ||
                                ((a_case_reg == CASE_BOTH) && (b_tot_next == 32'd0));
        b_item_next.vax       = a_vax_reg;
        b_item_next.vay       = a_vay_reg;
        b_item_next.vbx       = a_vbx_reg;
        b_item_next.vby       = a_vby_reg;
        b_item_next.nx        = a_nx_reg;
        b_item_next.ny        = a_ny_reg;
        b_item_next.excess    = (a_dep_reg > {10'd0, slop_reg}) ?
                                (a_dep_reg - {10'd0, slop_reg}) : 31'd0;
        case (a_case_reg)
            CASE_BOTH:
            begin
                b_item_next.dx = 33'(a_vbx_reg) - 33'(a_vax_reg);
                b_item_next.dy = 33'(a_vby_reg) - 33'(a_vay_reg);
            end
            CASE_B:
            begin
                b_item_next.dx = 33'(a_vbx_reg);
                b_item_next.dy = 33'(a_vby_reg);
            end
            default:
            begin
                b_item_next.dx = 33'(a_vax_reg);
                b_item_next.dy = 33'(a_vay_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            b_vld_reg <= 1'b0;
        end
        else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            b_ima_reg  <= a_ima_reg;
            b_imb_reg  <= a_imb_reg;
            b_tot_reg  <= b_tot_next;
            b_item_reg <= b_item_next;
        end
    end

    // Weight divider.
    logic               d_vld;
    logic [FRAC_BITS:0] d_wa;
    logic [FRAC_BITS:0] d_wb;
    cir_item_t          d_item;

    cir_wdiv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_wdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_vld_reg),
        .ima       (b_ima_reg),
        .imb       (b_imb_reg),
        .tot       (b_tot_reg),
        .in_item   (b_item_reg),
        .out_valid (d_vld),
        .wa        (d_wa),
        .wb        (d_wb),
        .out_item  (d_item)
    );

    // Post-divider stages.
    work_t            w0;
    work_t            pw_next [1:NPOST];
    work_t            pw_reg  [1:NPOST];
    logic [NPOST:1]   pv_reg;
    logic signed [FAC_W-1:0] one_e;

    assign one_e = ONE_Q + FAC_W'(restitution_reg);

    always_comb begin
        w0           = '0;
        w0.body_case = d_item.body_case;
        w0.skip      = d_item.skip;
        w0.vax       = d_item.vax;
        w0.vay       = d_item.vay;
        w0.vbx       = d_item.vbx;
        w0.vby       = d_item.vby;
        w0.nx        = d_item.nx;
        w0.ny        = d_item.ny;
        w0.excess    = d_item.excess;
        w0.dx        = d_item.dx;
        w0.dy        = d_item.dy;
        w0.wa        = d_wa;
        w0.wb        = d_wb;
    end

    // P1: correction and normal speed products.
    always_comb begin
        pw_next[1]          = w0;
        pw_next[1].corr_raw = 48'(w0.excess) * 48'(fraction_reg);
        pw_next[1].pdx      = 51'(w0.dx) * 51'(w0.nx);
        pw_next[1].pdy      = 51'(w0.dy) * 51'(w0.ny);
    end

    // P2: rescale the correction and the normal speed.
    always_comb begin
        pw_next[2]      = pw_reg[1];
        pw_next[2].corr = rescale(64'(signed'({1'b0, pw_reg[1].corr_raw})));
        pw_next[2].vn   = rescale(64'(pw_reg[1].pdx) + 64'(pw_reg[1].pdy));
    end

    // P3: restitution factor, impulse and weighted correction products. Two bodies act
    // when they approach (negative speed), a single body when its speed is not negative.
    logic                    p3_two;
    logic signed [MID_W:0]   p3_mag;
    logic signed [FAC_W-1:0] p3_fac;

    always_comb begin
        p3_two = (pw_reg[2].body_case == CASE_BOTH);
        p3_mag = p3_two ? -(MID_W+1)'(pw_reg[2].vn) : (MID_W+1)'(pw_reg[2].vn);
        p3_fac = (p3_mag < (MID_W+1)'(signed'({1'b0, resting_reg}))) ? ONE_Q : one_e;
        pw_next[3]          = pw_reg[2];
        pw_next[3].approach = p3_two ? pw_reg[2].vn[MID_W-1] : !pw_reg[2].vn[MID_W-1];
        pw_next[3].imp_raw  = 64'(pw_reg[2].vn) * 64'(p3_fac);
        pw_next[3].ca_raw   = 64'(pw_reg[2].corr) * 64'(signed'({1'b0, pw_reg[2].wa}));
        pw_next[3].cb_raw   = 64'(pw_reg[2].corr) * 64'(signed'({1'b0, pw_reg[2].wb}));
        pw_next[3].shx_raw  = 64'(pw_reg[2].corr) * 64'(pw_reg[2].nx);
        pw_next[3].shy_raw  = 64'(pw_reg[2].corr) * 64'(pw_reg[2].ny);
    end

    // P4: rescale impulse, weighted corrections and the single body shift.
    always_comb begin
        pw_next[4]      = pw_reg[3];
        pw_next[4].imp  = rescale(pw_reg[3].imp_raw);
        pw_next[4].ca   = rescale(pw_reg[3].ca_raw);
        pw_next[4].cb   = rescale(pw_reg[3].cb_raw);
        pw_next[4].sh1x = -rescale(pw_reg[3].shx_raw);
        pw_next[4].sh1y = -rescale(pw_reg[3].shy_raw);
    end

    // P5: weighted impulses, two body shift products and single body velocity products.
    always_comb begin
        pw_next[5]         = pw_reg[4];
        pw_next[5].ia_raw  = 64'(pw_reg[4].imp) * 64'(signed'({1'b0, pw_reg[4].wa}));
        pw_next[5].ib_raw  = 64'(pw_reg[4].imp) * 64'(signed'({1'b0, pw_reg[4].wb}));
        pw_next[5].tax_raw = 64'(pw_reg[4].ca) * 64'(pw_reg[4].nx);
        pw_next[5].tay_raw = 64'(pw_reg[4].ca) * 64'(pw_reg[4].ny);
        pw_next[5].tbx_raw = 64'(pw_reg[4].cb) * 64'(pw_reg[4].nx);
        pw_next[5].tby_raw = 64'(pw_reg[4].cb) * 64'(pw_reg[4].ny);
        pw_next[5].d1x_raw = 64'(pw_reg[4].imp) * 64'(pw_reg[4].nx);
        pw_next[5].d1y_raw = 64'(pw_reg[4].imp) * 64'(pw_reg[4].ny);
    end

    // P6: rescale them; body A is pushed against the normal.
    always_comb begin
        pw_next[6]     = pw_reg[5];
        pw_next[6].ia  = rescale(pw_reg[5].ia_raw);
        pw_next[6].ib  = rescale(pw_reg[5].ib_raw);
        pw_next[6].sax = -rescale(pw_reg[5].tax_raw);
        pw_next[6].say = -rescale(pw_reg[5].tay_raw);
        pw_next[6].sbx = rescale(pw_reg[5].tbx_raw);
        pw_next[6].sby = rescale(pw_reg[5].tby_raw);
        pw_next[6].d1x = rescale(pw_reg[5].d1x_raw);
        pw_next[6].d1y = rescale(pw_reg[5].d1y_raw);
    end

    // P7: two body velocity change products.
    always_comb begin
        pw_next[7]         = pw_reg[6];
        pw_next[7].uax_raw = 64'(pw_reg[6].ia) * 64'(pw_reg[6].nx);
        pw_next[7].uay_raw = 64'(pw_reg[6].ia) * 64'(pw_reg[6].ny);
        pw_next[7].ubx_raw = 64'(pw_reg[6].ib) * 64'(pw_reg[6].nx);
        pw_next[7].uby_raw = 64'(pw_reg[6].ib) * 64'(pw_reg[6].ny);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pv_reg <= '0;
        end
        else if (en) begin
            pv_reg <= {pv_reg[NPOST-1:1], d_vld};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 1; k <= NPOST; k++) begin
                pw_reg[k] <= pw_next[k];
            end
        end
    end

    assign last_vld = pv_reg[NPOST];

    // Final selection by body case, with saturation to 32 bits.
    work_t              f;
    logic signed [31:0] sax_next;
    logic signed [31:0] say_next;
    logic signed [31:0] sbx_next;
    logic signed [31:0] sby_next;
    logic signed [31:0] vax_next;
    logic signed [31:0] vay_next;
    logic signed [31:0] vbx_next;
    logic signed [31:0] vby_next;
    logic [1:0]         outc_next;

    always_comb begin
        f         = pw_reg[NPOST];
        sax_next  = '0;
        say_next  = '0;
        sbx_next  = '0;
        sby_next  = '0;
        vax_next  = f.vax;
        vay_next  = f.vay;
        vbx_next  = f.vbx;
        vby_next  = f.vby;
        outc_next = OUTC_SKIPPED;
        if (!f.skip) begin
            outc_next = f.approach ? OUTC_IMPULSE : OUTC_NO_CHANGE;
            case (f.body_case)
                CASE_BOTH:
                begin
                    sax_next = sat32(41'(f.sax));
                    say_next = sat32(41'(f.say));
                    sbx_next = sat32(41'(f.sbx));
                    sby_next = sat32(41'(f.sby));
                    if (f.approach) begin
                        vax_next = sat32(41'(f.vax) + 41'(rescale(f.uax_raw)));
                        vay_next = sat32(41'(f.vay) + 41'(rescale(f.uay_raw)));
                        vbx_next = sat32(41'(f.vbx) - 41'(rescale(f.ubx_raw)));
                        vby_next = sat32(41'(f.vby) - 41'(rescale(f.uby_raw)));
                    end
                end
                CASE_A:
                begin
                    sax_next = sat32(41'(f.sh1x));
                    say_next = sat32(41'(f.sh1y));
                    if (f.approach) begin
                        vax_next = sat32(41'(f.vax) - 41'(f.d1x));
                        vay_next = sat32(41'(f.vay) - 41'(f.d1y));
                    end
                end
                CASE_B:
                begin
                    sbx_next = sat32(41'(f.sh1x));
                    sby_next = sat32(41'(f.sh1y));
                    if (f.approach) begin
                        vbx_next = sat32(41'(f.vbx) - 41'(f.d1x));
                        vby_next = sat32(41'(f.vby) - 41'(f.d1y));
                    end
                end
                default:
                begin
                    outc_next = OUTC_SKIPPED;
                end
            endcase
        end
    end

    // Output register.
    logic               load;
    logic signed [31:0] sax_reg;
    logic signed [31:0] say_reg;
    logic signed [31:0] sbx_reg;
    logic signed [31:0] sby_reg;
    logic signed [31:0] vax_reg;
    logic signed [31:0] vay_reg;
    logic signed [31:0] vbx_reg;
    logic signed [31:0] vby_reg;
    logic [1:0]         outc_reg;

    assign load = last_vld && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (load) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            sax_reg  <= sax_next;
            say_reg  <= say_next;
            sbx_reg  <= sbx_next;
            sby_reg  <= sby_next;
            vax_reg  <= vax_next;
            vay_reg  <= vay_next;
            vbx_reg  <= vbx_next;
            vby_reg  <= vby_next;
            outc_reg <= outc_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.shift_a_x   = sax_reg;
    assign out_ch.shift_a_y   = say_reg;
    assign out_ch.shift_b_x   = sbx_reg;
    assign out_ch.shift_b_y   = sby_reg;
    assign out_ch.new_vel_a_x = vax_reg;
    assign out_ch.new_vel_a_y = vay_reg;
    assign out_ch.new_vel_b_x = vbx_reg;
    assign out_ch.new_vel_b_y = vby_reg;
    assign out_ch.outcome     = outc_reg;

endmodule
`default_nettype wire

### rtl/cir_checker.sv
// Port-level checker for the resolver and the bind that attaches it.
`default_nettype none
module cir_checker
    import cir_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] shift_a_x,
    input wire logic [31:0] shift_a_y,
    input wire logic [31:0] shift_b_x,
    input wire logic [31:0] shift_b_y,
    input wire logic [31:0] new_vel_a_x,
    input wire logic [1:0]  outcome
);

    // A held result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(new_vel_a_x)
            && $stable(shift_a_x))
        else $error("held result changed");

    // Input is refused only while a finished result waits at the output.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // A skipped contact moves no body.
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUTC_SKIPPED) |->
            shift_a_x == 32'd0 && shift_a_y == 32'd0 && shift_b_x == 32'd0 &&
            shift_b_y == 32'd0)
        else $error("skipped contact has nonzero shift");

endmodule

bind contact_impulse_resolver cir_checker u_cir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .shift_a_x   (out_ch.shift_a_x),
    .shift_a_y   (out_ch.shift_a_y),
    .shift_b_x   (out_ch.shift_b_x),
    .shift_b_y   (out_ch.shift_b_y),
    .new_vel_a_x (out_ch.new_vel_a_x),
    .outcome     (out_ch.outcome)
);
`default_nettype wire
